FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define SBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Widths, register codes, beat structs and bank helpers of the mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbm_pkg;

	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int COUNT_W    = 7;
	localparam int REG_W      = 5;
	localparam int CHR_W      = 5;
	localparam int PRG_W      = 6;
	localparam int MIR_W      = 2;
	localparam int SHIFT_W    = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// five serial bits load one register
	localparam logic [SHIFT_W-1:0] SHIFT_LEN       = 3'd5;
	localparam logic [REG_W-1:0]   CTRL_RESET      = 5'h0C;
	localparam logic [REG_W-1:0]   CTRL_FORCE_BITS = 5'h0C;
	localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 7'd8;
	localparam logic [COUNT_W-1:0] LARGE_MIN       = 7'd32;
	localparam logic [PRG_W-1:0]   LARGE_FIXED_HI  = 6'd15;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CfgPrgBankCount = 1'b0,
		CfgChrIsRom     = 1'b1
	} cfg_reg_t;

	// register selected by address bits 14:13
	typedef enum logic [1:0] {
		RegControl = 2'd0,
		RegChr0    = 2'd1,
		RegChr1    = 2'd2,
		RegPrg     = 2'd3
	} mreg_t;

	typedef struct packed {
		mreg_t region;
		logic  reset_bit;
		logic  serial_bit;
	} item_t;

	typedef struct packed {
		logic [MIR_W-1:0] mirroring;
		logic [CHR_W-1:0] chr_low_bank;
		logic [CHR_W-1:0] chr_high_bank;
		logic [PRG_W-1:0] prg_low_bank;
		logic [PRG_W-1:0] prg_high_bank;
		logic [REG_W-1:0] control_value;
	} result_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] shift_count;
	} status_t;

	function automatic logic [PRG_W-1:0] last_bank(input logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] m;
		m = count - 7'd1;
		return m[PRG_W-1:0];
	endfunction

	function automatic logic [PRG_W-1:0] power_on_high(input logic [COUNT_W-1:0] count);
		return (count >= LARGE_MIN) ? LARGE_FIXED_HI : last_bank(count);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sbm_if.sv
// ----------------------------------------------------------------------------
// sbm_if
// Valid/ready channels: CPU write beats in, bank mapping beats out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbm_wr_if;
	logic                        valid;
	logic                        ready;
	logic [sbm_pkg::ADDR_W-1:0]  cpu_address;
	logic [sbm_pkg::DATA_W-1:0]  write_data;

	modport source (output valid, output cpu_address, output write_data, input ready);
	modport sink   (input valid, input cpu_address, input write_data, output ready);
endinterface

interface sbm_map_if;
	logic                       valid;
	logic                       ready;
	logic [sbm_pkg::MIR_W-1:0]  mirroring;
	logic [sbm_pkg::CHR_W-1:0]  chr_low_bank;
	logic [sbm_pkg::CHR_W-1:0]  chr_high_bank;
	logic [sbm_pkg::PRG_W-1:0]  prg_low_bank;
	logic [sbm_pkg::PRG_W-1:0]  prg_high_bank;
	logic [sbm_pkg::REG_W-1:0]  control_value;

	modport source (output valid, output mirroring, output chr_low_bank, output chr_high_bank,
		output prg_low_bank, output prg_high_bank, output control_value, input ready);
	modport sink   (input valid, input mirroring, input chr_low_bank, input chr_high_bank,
		input prg_low_bank, input prg_high_bank, input control_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sbm_regfile.sv
// ----------------------------------------------------------------------------
// sbm_regfile
// Serial shifter, four mapper registers and slot bank state with update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbm_regfile (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  sbm_pkg::item_t                   item,
	input  logic [sbm_pkg::COUNT_W-1:0]      prg_bank_count,
	input  logic                             chr_is_rom,
	input  logic                             prg_reload,
	input  logic [sbm_pkg::COUNT_W-1:0]      reload_count,
	output sbm_pkg::result_t                 result_next,
	output sbm_pkg::status_t                 status
);
	import sbm_pkg::*;

	logic [SHIFT_W-1:0] shift_count_q, shift_count_n;
	logic [REG_W-1:0]   shift_buf_q, shift_buf_n;
	logic [REG_W-1:0]   regs_q [4];
	logic [REG_W-1:0]   regs_n [4];
	mreg_t              last_region_q;
	logic [MIR_W-1:0]   mirror_q, mirror_n;
	logic [CHR_W-1:0]   chr_lo_q, chr_lo_n, chr_hi_q, chr_hi_n;
	logic [PRG_W-1:0]   prg_lo_q, prg_lo_n, prg_hi_q, prg_hi_n;

	logic [SHIFT_W-1:0] cnt;
	logic [REG_W-1:0]   sbuf;
	logic [REG_W-1:0]   sh_val;
	logic [SHIFT_W-1:0] cnt_inc;
	logic [REG_W-1:0]   ctl, r1, r2, r3;
	logic               large_cart;
	logic               chr_act, upd_lo, upd_hi, prg_act;
	logic [PRG_W-1:0]   base;

	assign large_cart = prg_bank_count >= LARGE_MIN;

	// next state for one write beat
	always_comb begin
		cnt = (item.region != last_region_q) ? '0 : shift_count_q;
		sbuf = (item.region != last_region_q) ? '0 : shift_buf_q;
		sh_val = sbuf | ({{(REG_W-1){1'b0}}, item.serial_bit} << cnt);
		cnt_inc = cnt + 3'd1;
		shift_count_n = cnt;
		shift_buf_n = sbuf;
		for (int i = 0; i < 4; i++) begin
			regs_n[i] = regs_q[i];
		end
		mirror_n = mirror_q;
		chr_lo_n = chr_lo_q;
		chr_hi_n = chr_hi_q;
		prg_lo_n = prg_lo_q;
		prg_hi_n = prg_hi_q;
		ctl = '0;
		r1 = '0;
		r2 = '0;
		r3 = '0;
		chr_act = 1'b0;
		upd_lo = 1'b0;
		upd_hi = 1'b0;
		prg_act = 1'b0;
		base = '0;

		if (item.reset_bit) begin
			shift_count_n = '0;
			shift_buf_n = '0;
			regs_n[RegControl] = regs_q[RegControl] | CTRL_FORCE_BITS;
		end else if (cnt_inc != SHIFT_LEN) begin
			shift_count_n = cnt_inc;
			shift_buf_n = sh_val;
		end else begin
			// fifth bit: load the register and refresh its slots (all slots on large carts)
			shift_count_n = '0;
			shift_buf_n = '0;
			regs_n[item.region] = sh_val;
			if (item.region == RegControl) begin
				mirror_n = sh_val[MIR_W-1:0];
			end
			ctl = regs_n[RegControl];
			r1 = regs_n[RegChr0];
			r2 = regs_n[RegChr1];
			r3 = regs_n[RegPrg];

			if (large_cart) begin
				chr_act = 1'b1;
				upd_lo = 1'b1;
				upd_hi = 1'b1;
				prg_act = 1'b1;
			end else begin
				unique case (item.region)
					RegChr0: begin
						chr_act = 1'b1;
						upd_lo = 1'b1;
						upd_hi = chr_is_rom;
					end
					RegChr1: begin
						chr_act = 1'b1;
						upd_lo = chr_is_rom;
						upd_hi = 1'b1;
					end
					RegPrg: begin
						prg_act = 1'b1;
					end
					default: begin
						chr_act = 1'b0;
					end
				endcase
			end

			// character slots: 4K pair from registers one and two, 8K pair from register one
			if (chr_act) begin
				if (ctl[4]) begin
					if (upd_lo) chr_lo_n = r1;
					if (upd_hi) chr_hi_n = r2;
				end else if (chr_is_rom) begin
					chr_lo_n = {r1[4:1], 1'b0};
					chr_hi_n = {r1[4:1], 1'b1};
				end
			end

			// program slots; large carts add a 256K outer base
			if (prg_act) begin
				if (large_cart) begin
					base = {1'b0, r1[4], 4'b0000};
					if (!ctl[3]) begin
						prg_lo_n = {base[5:4], r3[3:1], 1'b0};
						prg_hi_n = {base[5:4], r3[3:1], 1'b1};
					end else if (ctl[2]) begin
						prg_lo_n = {base[5:4], r3[3:0]};
						prg_hi_n = base | LARGE_FIXED_HI;
					end else begin
						prg_lo_n = base;
						prg_hi_n = {base[5:4], r3[3:0]};
					end
				end else begin
					if (!ctl[3]) begin
						prg_lo_n = {1'b0, r3[4:1], 1'b0};
						prg_hi_n = {1'b0, r3[4:1], 1'b1};
					end else if (ctl[2]) begin
						prg_lo_n = {1'b0, r3};
						prg_hi_n = last_bank(prg_bank_count);
					end else begin
						prg_lo_n = '0;
						prg_hi_n = {1'b0, r3};
					end
				end
			end
		end
	end

	// hold state; advance on a beat, reload PRG slots on a size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_count_q <= '0;
			shift_buf_q <= '0;
			regs_q[RegControl] <= CTRL_RESET;
			regs_q[RegChr0] <= '0;
			regs_q[RegChr1] <= '0;
			regs_q[RegPrg] <= '0;
			last_region_q <= RegControl;
			mirror_q <= '0;
			chr_lo_q <= 5'd0;
			chr_hi_q <= 5'd1;
			prg_lo_q <= '0;
			prg_hi_q <= power_on_high(PRG_COUNT_RESET);
		end else if (prg_reload) begin
			prg_lo_q <= '0;
			prg_hi_q <= power_on_high(reload_count);
		end else if (step) begin
			shift_count_q <= shift_count_n;
			shift_buf_q <= shift_buf_n;
			for (int i = 0; i < 4; i++) begin
				regs_q[i] <= regs_n[i];
			end
			last_region_q <= item.region;
			mirror_q <= mirror_n;
			chr_lo_q <= chr_lo_n;
			chr_hi_q <= chr_hi_n;
			prg_lo_q <= prg_lo_n;
			prg_hi_q <= prg_hi_n;
		end
	end

	assign result_next.mirroring = mirror_n;
	assign result_next.chr_low_bank = chr_lo_n;
	assign result_next.chr_high_bank = chr_hi_n;
	assign result_next.prg_low_bank = prg_lo_n;
	assign result_next.prg_high_bank = prg_hi_n;
	assign result_next.control_value = regs_n[RegControl];
	assign status.shift_count = shift_count_q;

endmodule

`default_nettype wire

FILE: hw/rtl/serial_loaded_bank_mapper.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper
// Serially loaded bank mapper: CPU write beats in, bank mapping beats out.
// ----------------------------------------------------------------------------
// Usage:
//   wr carries one CPU write to cartridge space per beat (cpu_address,
//   write_data). map returns one beat per write: mirroring, the two 4K
//   character banks, the two 16K program banks and the control register,
//   all as they stand after that write.
//   A wr beat is held in the input register, then passes through the register
//   update into the result register. Throughput is one beat per cycle while
//   the map channel is not stalled; the single update pass between input and
//   result registers sets that rate.
//   Both stages advance together; a stalled map beat holds the result
//   register and drops wr.ready until the receiver takes it.
//   cfg_we/cfg_index/cfg_data write prg_bank_count (index 0, also reloads the
//   power-on program mapping) and chr_is_rom (index 1); the user writes them
//   only while idle, the block does not enforce it. Reset gives control 0x0C,
//   character banks 0 and 1, program banks 0 and the last, no beat in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module serial_loaded_bank_mapper (
	input  logic                              clk,
	input  logic                              arst_n,
	sbm_wr_if.sink                            wr,
	sbm_map_if.source                         map,
	input  logic                              cfg_we,
	input  logic [sbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sbm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sbm_pkg::*;

	logic [COUNT_W-1:0] prg_bank_count_q;
	logic               chr_is_rom_q;
	logic               prg_reload;
	logic               advance;
	logic               valid_s1;
	item_t              item_s1;
	logic               out_valid_q;
	result_t            result_q;
	result_t            result_next;
	status_t            status;
	logic               step;

	// both stages move when the result register is free or being taken
	assign advance = !out_valid_q || map.ready;
	assign wr.ready = advance;
	assign step = advance && valid_s1;
	assign prg_reload = cfg_we && (cfg_reg_t'(cfg_index) == CfgPrgBankCount);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_count_q <= PRG_COUNT_RESET;
			chr_is_rom_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CfgPrgBankCount: prg_bank_count_q <= cfg_data[COUNT_W-1:0];
				CfgChrIsRom:     chr_is_rom_q <= cfg_data[0];
				default:         chr_is_rom_q <= chr_is_rom_q;
			endcase
		end
	end

	// input stage: keep only region, reset bit and serial bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= wr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr.valid) begin
			item_s1.region <= mreg_t'(wr.cpu_address[14:13]);
			item_s1.reset_bit <= wr.write_data[7];
			item_s1.serial_bit <= wr.write_data[0];
		end
	end

	sbm_regfile u_regfile (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.item           (item_s1),
		.prg_bank_count (prg_bank_count_q),
		.chr_is_rom     (chr_is_rom_q),
		.prg_reload     (prg_reload),
		.reload_count   (cfg_data[COUNT_W-1:0]),
		.result_next    (result_next),
		.status         (status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_next;
		end
	end

	assign map.valid = out_valid_q;
	assign map.mirroring = result_q.mirroring;
	assign map.chr_low_bank = result_q.chr_low_bank;
	assign map.chr_high_bank = result_q.chr_high_bank;
	assign map.prg_low_bank = result_q.prg_low_bank;
	assign map.prg_high_bank = result_q.prg_high_bank;
	assign map.control_value = result_q.control_value;

	// checks
	`SBM_ASSERT_IMPLY(a_shift_bound, clk, arst_n, 1'b1, status.shift_count < SHIFT_LEN, "shift count reached register length")
	`SBM_ASSERT_IMPLY(a_stall_blocks, clk, arst_n, map.valid && !map.ready, !wr.ready, "write taken while result stalled")
	`SBM_ASSERT_NEXT(a_reset_forces, clk, arst_n, step && item_s1.reset_bit, result_q.control_value[3:2] == 2'b11, "reset beat did not force control bits")

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serially loaded bank mapper. CPU write beats go
// in on the wr channel. An in-bench copy of the mapper state predicts the bank
// map that each write leaves behind, and every map beat is compared field by
// field with the oldest prediction. The run covers directed loads, several
// cart sizes with CHR ROM and RAM, a long output stall and a gap-free stretch.
// ----------------------------------------------------------------------------

module testbench;
	import sbm_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sbm_wr_if  wr_ch ();
	sbm_map_if map_ch ();

	serial_loaded_bank_mapper u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr_ch),
		.map       (map_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mapper state as the bench sees it
	logic [COUNT_W-1:0] bank_count;
	logic               rom_chr;
	logic [SHIFT_W-1:0] shift_cnt;
	logic [REG_W-1:0]   shift_bits;
	logic [REG_W-1:0]   mregs [4];
	mreg_t              prev_region;
	logic [MIR_W-1:0]   mirror_now;
	logic [CHR_W-1:0]   chr_bank [2];
	logic [PRG_W-1:0]   prg_bank [2];

	result_t pending_maps [$];

	int beats_sent;
	int maps_checked;
	int mismatches;
	int settings_run;

	// traffic shaping shared with the receiver
	bit no_gaps;
	int stall_len;
	bit stall_go;

	// ------------------------------------------------------------------
	// bank map prediction
	// ------------------------------------------------------------------
	function automatic logic [PRG_W-1:0] top_bank();
		logic [COUNT_W-1:0] t;
		t = bank_count - 7'd1;
		return t[PRG_W-1:0];
	endfunction

	function automatic void load_power_on();
		prg_bank[0] = '0;
		prg_bank[1] = (bank_count >= 7'd32) ? 6'd15 : top_bank();
	endfunction

	function automatic void reset_mapper();
		bank_count  = 7'd8;
		rom_chr     = 1'b1;
		shift_cnt   = '0;
		shift_bits  = '0;
		mregs[0]    = 5'h0C;
		mregs[1]    = '0;
		mregs[2]    = '0;
		mregs[3]    = '0;
		prev_region = RegControl;
		mirror_now  = '0;
		chr_bank[0] = 5'd0;
		chr_bank[1] = 5'd1;
		load_power_on();
	endfunction

	function automatic void remap_chr(input bit upd_low, input bit upd_high);
		if (mregs[RegControl][4]) begin
			if (upd_low)
				chr_bank[0] = mregs[RegChr0];
			if (upd_high)
				chr_bank[1] = mregs[RegChr1];
		end else if (rom_chr) begin
			// 8K mode: even bank low, odd partner high
			chr_bank[0] = mregs[RegChr0] & 5'h1E;
			chr_bank[1] = chr_bank[0] | 5'h01;
		end
	endfunction

	function automatic void remap_prg();
		logic [REG_W-1:0] ctl;
		logic [REG_W-1:0] r3;
		logic [PRG_W-1:0] base;
		ctl  = mregs[RegControl];
		r3   = mregs[RegPrg];
		base = {1'b0, mregs[RegChr0][4], 4'b0};
		if (bank_count >= 7'd32) begin
			// large cart: 256K outer window picked by CHR register bit 4
			if (!ctl[3]) begin
				prg_bank[0] = base + 6'(r3 & 5'h0E);
				prg_bank[1] = prg_bank[0] + 6'd1;
			end else if (ctl[2]) begin
				prg_bank[0] = base + 6'(r3 & 5'h0F);
				prg_bank[1] = base + 6'd15;
			end else begin
				prg_bank[0] = base;
				prg_bank[1] = base + 6'(r3 & 5'h0F);
			end
		end else begin
			if (!ctl[3]) begin
				prg_bank[0] = 6'(r3 & 5'h1E);
				prg_bank[1] = prg_bank[0] | 6'd1;
			end else if (ctl[2]) begin
				prg_bank[0] = 6'(r3);
				prg_bank[1] = top_bank();
			end else begin
				prg_bank[0] = '0;
				prg_bank[1] = 6'(r3);
			end
		end
	endfunction

	function automatic result_t apply_cpu_write(input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		mreg_t   region;
		result_t map;
		region = mreg_t'(addr[14:13]);
		// a write to another 8K region restarts the serial load
		if (region != prev_region) begin
			shift_cnt  = '0;
			shift_bits = '0;
		end
		prev_region = region;
		if (data[7]) begin
			shift_cnt  = '0;
			shift_bits = '0;
			mregs[RegControl] = mregs[RegControl] | 5'h0C;
		end else begin
			if (data[0])
				shift_bits[shift_cnt] = 1'b1;
			shift_cnt = shift_cnt + 3'd1;
			if (shift_cnt >= 3'd5) begin
				mregs[region] = shift_bits;
				shift_bits    = '0;
				shift_cnt     = '0;
				if (region == RegControl)
					mirror_now = mregs[RegControl][1:0];
				if (bank_count >= 7'd32) begin
					remap_chr(1'b1, 1'b1);
					remap_prg();
				end else begin
					case (region)
						RegChr0: remap_chr(1'b1, rom_chr);
						RegChr1: remap_chr(rom_chr, 1'b1);
						RegPrg:  remap_prg();
						default: ;
					endcase
				end
			end
		end
		map.mirroring     = mirror_now;
		map.chr_low_bank  = chr_bank[0];
		map.chr_high_bank = chr_bank[1];
		map.prg_low_bank  = prg_bank[0];
		map.prg_high_bank = prg_bank[1];
		map.control_value = mregs[RegControl];
		return map;
	endfunction

	// ------------------------------------------------------------------
	// clock, receiver, map checker, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drop ready at random, or for a whole requested stall
	initial begin : receiver
		bit stall_seen;
		int stall_left;
		stall_seen = 1'b0;
		stall_left = 0;
		map_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_go != stall_seen) begin
				stall_seen = stall_go;
				stall_left = stall_len;
			end
			if (stall_left > 0) begin
				stall_left--;
				map_ch.ready <= 1'b0;
			end else begin
				map_ch.ready <= no_gaps || ($urandom_range(99) >= 36);
			end
		end
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("MISMATCH %s: got %0d, want %0d (map beat %0d)", what, got, want,
				maps_checked);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_map
		result_t want;
		if (arst_n && map_ch.valid && map_ch.ready) begin
			if (pending_maps.size() == 0) begin
				flag_mismatch("map beat with no write pending", 0, 0);
			end else begin
				want = pending_maps.pop_front();
				if (map_ch.mirroring !== want.mirroring)
					flag_mismatch("mirroring", map_ch.mirroring, want.mirroring);
				if (map_ch.chr_low_bank !== want.chr_low_bank)
					flag_mismatch("chr_low_bank", map_ch.chr_low_bank, want.chr_low_bank);
				if (map_ch.chr_high_bank !== want.chr_high_bank)
					flag_mismatch("chr_high_bank", map_ch.chr_high_bank, want.chr_high_bank);
				if (map_ch.prg_low_bank !== want.prg_low_bank)
					flag_mismatch("prg_low_bank", map_ch.prg_low_bank, want.prg_low_bank);
				if (map_ch.prg_high_bank !== want.prg_high_bank)
					flag_mismatch("prg_high_bank", map_ch.prg_high_bank, want.prg_high_bank);
				if (map_ch.control_value !== want.control_value)
					flag_mismatch("control_value", map_ch.control_value, want.control_value);
				maps_checked++;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d map beats still pending", pending_maps.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// shared drive tasks
	// ------------------------------------------------------------------
	// offer one write beat, hold it until taken, then predict its map
	task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		while (!no_gaps && $urandom_range(99) < 36) begin
			wr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		wr_ch.valid       <= 1'b1;
		wr_ch.cpu_address <= addr;
		wr_ch.write_data  <= data;
		@(posedge clk);
		while (!wr_ch.ready)
			@(posedge clk);
		pending_maps.push_back(apply_cpu_write(addr, data));
		beats_sent++;
	endtask

	function automatic logic [ADDR_W-1:0] addr_in(input mreg_t r);
		return {1'b1, r, 13'($urandom)};
	endfunction

	// five serial beats, LSB first, junk in data bits 6:1; region bits from r
	task automatic load_reg(input mreg_t r, input logic [REG_W-1:0] value,
			input logic [ADDR_W-1:0] addr);
		for (int i = 0; i < 5; i++)
			send_write({addr[15], r, addr[12:0]}, {1'b0, 6'($urandom), value[i]});
	endtask

	task automatic wait_for_drain();
		wr_ch.valid <= 1'b0;
		while (pending_maps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CfgPrgBankCount) begin
			bank_count = value;
			load_power_on();
		end else begin
			rom_chr = value[0];
		end
		@(posedge clk);
	endtask

	// mostly complete serial loads, some cut short, some pure noise
	task automatic random_traffic(input int n_beats);
		int    sent;
		int    kind;
		int    len;
		mreg_t r;
		sent = 0;
		while (sent < n_beats) begin
			kind = $urandom_range(99);
			r    = mreg_t'($urandom_range(3));
			if (kind < 70) begin
				if ($urandom_range(3) == 0) begin
					send_write(addr_in(r), 8'h80 | 8'($urandom_range(127)));
					sent++;
				end
				load_reg(r, 5'($urandom), addr_in(r));
				sent += 5;
			end else if (kind < 85) begin
				len = $urandom_range(4, 1);
				for (int i = 0; i < len; i++)
					send_write(addr_in(r), {1'b0, 7'($urandom)});
				sent += len;
				if ($urandom_range(1)) begin
					send_write(addr_in(r), 8'h80 | 8'($urandom));
					sent++;
				end
			end else begin
				send_write(16'($urandom), 8'($urandom));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed_loads();
		// reset bit first: power-on map with control forced
		send_write(16'h8000, 8'h80);
		load_reg(RegControl, 5'h1F, 16'h9FFF);
		load_reg(RegChr0, 5'h1F, 16'hA000);
		load_reg(RegChr1, 5'h00, 16'hDFFF);
		// partial load dropped by the reset bit
		send_write(16'hE000, 8'h01);
		send_write(16'hE000, 8'h7F);
		send_write(16'hFFFF, 8'hFF);
		// partial load dropped by a region change
		send_write(16'h8000, 8'h01);
		load_reg(RegPrg, 5'h1F, 16'hFFFF);
		send_write(16'hE000, 8'h00);
		wait_for_drain();
	endtask

	task automatic test_cart_sizes();
		logic [COUNT_W-1:0] sizes [8] = '{7'd2, 7'd0, 7'd31, 7'd32, 7'd64, 7'd127, 7'd16,
			7'd48};
		bit                 roms  [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		for (int i = 0; i < 8; i++) begin
			wait_for_drain();
			write_reg(CfgPrgBankCount, sizes[i]);
			write_reg(CfgChrIsRom, {6'($urandom), roms[i]});
			settings_run++;
			random_traffic(55);
		end
		wait_for_drain();
	endtask

	task automatic test_output_stall();
		// hold the output off while writes keep coming
		stall_len = 80;
		stall_go  = ~stall_go;
		for (int i = 0; i < 5; i++)
			load_reg(mreg_t'($urandom_range(3)), 5'($urandom), addr_in(mreg_t'(i % 4)));
		// pause the sender until every map beat is back
		wait_for_drain();
	endtask

	task automatic test_gap_free_stream();
		no_gaps = 1'b1;
		random_traffic(60);
		wait_for_drain();
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n            <= 1'b0;
		wr_ch.valid       <= 1'b0;
		wr_ch.cpu_address <= '0;
		wr_ch.write_data  <= '0;
		cfg_we            <= 1'b0;
		cfg_index         <= CfgPrgBankCount;
		cfg_data          <= '0;
		no_gaps      = 1'b0;
		stall_len    = 0;
		stall_go     = 1'b0;
		beats_sent   = 0;
		maps_checked = 0;
		mismatches   = 0;
		settings_run = 1;
		reset_mapper();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_loads();
		test_cart_sizes();
		test_output_stall();
		test_gap_free_stream();

		wait_for_drain();
		repeat (8) @(posedge clk);
		$display("Run: %0d CPU writes under %0d cart settings, %0d bank maps compared,",
			beats_sent, settings_run, maps_checked);
		$display("with a long output stall, a drained pause and a gap-free stretch.");
		if (mismatches == 0 && pending_maps.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
